/* sv/wrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_pkg
// Shared types and constants of the weighted random host selector.
// ----------------------------------------------------------------------------
package wrs_pkg;

   localparam int MAX_TARGETS = 16;
   localparam int IDX_W       = $clog2(MAX_TARGETS);
   localparam int CNT_W       = IDX_W + 1;
   localparam int CSR_W       = 7;
   localparam int SUM_W       = 32 + IDX_W;
   localparam int THR_W       = SUM_W + 16;
   localparam logic [6:0] STREAK_LIMIT = 7'd100;
   // floor(x / 100) as (x * 5243) >> 19, exact for x below 43699
   localparam logic [12:0] DIV100_MUL = 13'd5243;

   // register indexes of the configuration port
   localparam logic [1:0] CSR_HOST_COUNT = 2'd0;
   localparam logic [1:0] CSR_AVAIL_RATIO = 2'd1;
   localparam logic [1:0] CSR_WEIGHT_SRC = 2'd2;

   typedef enum logic [1:0] {
      MODE_STAGE   = 2'd0,
      MODE_HB_OK   = 2'd1,
      MODE_HB_PART = 2'd2,
      MODE_CHOOSE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      HOW_COUNTER  = 2'd0,
      HOW_RR       = 2'd1,
      HOW_WEIGHTED = 2'd2,
      HOW_FALLBACK = 2'd3
   } how_type;

   typedef enum logic [1:0] {
      SEL_NONE = 2'd0,
      SEL_MOD  = 2'd1,
      SEL_SCAN = 2'd2
   } sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COMMIT,
      ST_DECIDE,
      ST_SCAN_MAX,
      ST_RATIO,
      ST_SCAN_SUM,
      ST_MULT,
      ST_SCAN_PICK,
      ST_MOD
   } state_type;

   typedef struct packed {
      mode_type     mode;
      logic [3:0]   target_index;
      logic         status_present;
      logic [31:0]  free_cache;
      logic [15:0]  inflight_requests;
      logic         counter_given;
      logic [30:0]  global_count;
      logic [15:0]  random_fraction;
   } req_type;

   typedef struct packed {
      logic [3:0] chosen_target;
      logic       target_found;
      how_type    how_chosen;
   } rsp_type;

   typedef struct packed {
      logic    stage_write;
      logic    load_req;
      logic    idx_clear;
      logic    idx_step;
      logic    commit_step;
      logic    max_step;
      logic    sum_step;
      logic    mult;
      logic    mod_start;
      logic    mod_from_rr;
      logic    rr_advance;
      logic    streak_clear;
      logic    streak_inc;
      logic    emit;
      sel_type sel;
      how_type how;
   } cmd_type;

   typedef struct packed {
      logic idx_last;
      logic n_zero;
      logic counter_given;
      logic rr_needed;
      logic pick_hit;
      logic mod_busy;
      logic mod_done;
      logic streak_full;
   } status_type;

endpackage

/* sv/wrs_mod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_mod
// Bit-serial restoring remainder of a 32-bit value by a target count.
// ----------------------------------------------------------------------------
module wrs_mod (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [31:0]              dividend,
   input  logic [wrs_pkg::CNT_W-1:0] divisor,
   output logic                     busy,
   output logic                     done,
   output logic [wrs_pkg::IDX_W-1:0] remainder
);
   import wrs_pkg::*;

   logic [31:0]      shift_ff, shift_in;
   logic [IDX_W-1:0] rem_ff, rem_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] trial;

   // one quotient bit per cycle
   always_comb begin
      trial    = {rem_ff, shift_ff[31]};
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[30:0], 1'b0};
         if (trial >= divisor) rem_in = IDX_W'(trial - divisor);
         else rem_in = trial[IDX_W-1:0];
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign remainder = rem_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("remainder done without a run");
endmodule

/* sv/wrs_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_datapath
// Status tables, configuration, scan accumulators and result register.
// ----------------------------------------------------------------------------
module wrs_datapath (
   input  logic                clock,
   input  logic                reset,
   input  wrs_pkg::req_type    req_data,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [wrs_pkg::CSR_W-1:0] csr_wdata,
   input  wrs_pkg::cmd_type    cmd,
   output wrs_pkg::status_type status,
   output logic                rsp_valid,
   output wrs_pkg::rsp_type    rsp_data
);
   import wrs_pkg::*;

   // configuration
   logic [4:0] host_count_ff;
   logic [6:0] avail_ratio_ff;
   logic       weight_src_ff;

   // staged and active status tables
   logic [MAX_TARGETS-1:0] st_present_ff;
   logic [31:0]            st_cache_ff [MAX_TARGETS];
   logic [15:0]            st_inf_ff   [MAX_TARGETS];
   logic [MAX_TARGETS-1:0] ac_present_ff;
   logic [31:0]            ac_cache_ff [MAX_TARGETS];
   logic [15:0]            ac_inf_ff   [MAX_TARGETS];

   logic [31:0]      rr_ff;
   logic [6:0]       streak_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [CNT_W-1:0] rep_cnt_ff;
   logic [15:0]      max_inf_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] acc_ff;
   logic [THR_W-1:0] thr_ff;
   logic             cnt_given_ff;
   logic [30:0]      global_ff;
   logic [15:0]      rand_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic [CNT_W-1:0] n_eff;
   logic             in_group;
   logic [31:0]      weight;
   logic [SUM_W-1:0] acc_in;
   logic [11:0]      ratio_prod;
   logic [24:0]      ratio_scaled;
   logic [CNT_W-1:0] ratio_thr;
   logic             mod_busy, mod_done;
   logic [IDX_W-1:0] mod_rem;
   logic [31:0]      mod_dividend;

   // group size clamped to the table depth
   assign n_eff    = (host_count_ff > CNT_W'(MAX_TARGETS)) ? CNT_W'(MAX_TARGETS)
                                                           : host_count_ff;
   assign in_group = ({1'b0, idx_ff} < n_eff) && ac_present_ff[idx_ff];
   assign weight   = weight_src_ff ? {16'd0, max_inf_ff - ac_inf_ff[idx_ff]}
                                   : ac_cache_ff[idx_ff];
   assign acc_in   = acc_ff + SUM_W'(weight);

   // reported targets needed: n * ratio / 100
   assign ratio_prod   = 12'({7'd0, n_eff} * {5'd0, avail_ratio_ff});
   assign ratio_scaled = 25'({13'd0, ratio_prod} * {12'd0, DIV100_MUL});
   assign ratio_thr    = ratio_scaled[23:19];

   assign mod_dividend = cmd.mod_from_rr ? rr_ff : {1'b0, global_ff};

   wrs_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (mod_dividend),
      .divisor   (n_eff),
      .busy      (mod_busy),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      status.idx_last      = (idx_ff == IDX_W'(MAX_TARGETS - 1));
      status.n_zero        = (n_eff == '0);
      status.counter_given = cnt_given_ff;
      status.rr_needed     = (rep_cnt_ff < ratio_thr);
      status.pick_hit      = in_group && ({acc_in, 16'd0} >= thr_ff);
      status.mod_busy      = mod_busy;
      status.mod_done      = mod_done;
      status.streak_full   = (streak_ff == STREAK_LIMIT);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         host_count_ff  <= '0;
         avail_ratio_ff <= '0;
         weight_src_ff  <= 1'b0;
         st_present_ff  <= '0;
         ac_present_ff  <= '0;
         rr_ff          <= '0;
         streak_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_HOST_COUNT:  host_count_ff  <= csr_wdata[4:0];
               CSR_AVAIL_RATIO: avail_ratio_ff <= csr_wdata;
               CSR_WEIGHT_SRC:  weight_src_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
         if (cmd.stage_write)
            st_present_ff[req_data.target_index] <= req_data.status_present;
         if (cmd.commit_step)
            ac_present_ff[idx_ff] <= st_present_ff[idx_ff];
         if (cmd.rr_advance) rr_ff <= rr_ff + 32'd1;
         if (cmd.streak_clear) streak_ff <= '0;
         else if (cmd.streak_inc) streak_ff <= streak_ff + 7'd1;
         rsp_valid_ff <= cmd.emit;
      end
   end

   // table payload, scan accumulators and result
   always_ff @(posedge clock) begin
      if (cmd.stage_write) begin
         st_cache_ff[req_data.target_index] <= req_data.free_cache;
         st_inf_ff[req_data.target_index]   <= req_data.inflight_requests;
      end
      if (cmd.commit_step) begin
         ac_cache_ff[idx_ff] <= st_cache_ff[idx_ff];
         ac_inf_ff[idx_ff]   <= st_inf_ff[idx_ff];
      end
      if (cmd.idx_clear) idx_ff <= '0;
      else if (cmd.idx_step) idx_ff <= idx_ff + IDX_W'(1);
      if (cmd.load_req) begin
         cnt_given_ff <= req_data.counter_given;
         global_ff    <= req_data.global_count;
         rand_ff      <= req_data.random_fraction;
         rep_cnt_ff   <= '0;
         max_inf_ff   <= '0;
         sum_ff       <= '0;
         acc_ff       <= '0;
      end
      if (cmd.max_step && ac_present_ff[idx_ff]) begin
         rep_cnt_ff <= rep_cnt_ff + CNT_W'(1);
         if (ac_inf_ff[idx_ff] > max_inf_ff) max_inf_ff <= ac_inf_ff[idx_ff];
      end
      if (cmd.sum_step && in_group) sum_ff <= sum_ff + SUM_W'(weight);
      if (cmd.mult) thr_ff <= {16'd0, sum_ff} * {{(THR_W-16){1'b0}}, rand_ff};
      if (cmd.idx_step && !cmd.sum_step && !cmd.max_step && !cmd.commit_step
          && in_group)
         acc_ff <= acc_in;
      if (cmd.emit) begin
         rsp_ff.target_found <= (cmd.sel != SEL_NONE);
         rsp_ff.how_chosen   <= cmd.how;
         unique case (cmd.sel)
            SEL_MOD:  rsp_ff.chosen_target <= mod_rem;
            SEL_SCAN: rsp_ff.chosen_target <= idx_ff;
            default:  rsp_ff.chosen_target <= '0;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff) else $error("result strobe longer than one beat");
   a_rr_on_rr_pick: assert property (@(posedge clock) disable iff (reset)
      cmd.rr_advance |-> cmd.emit && cmd.sel == SEL_MOD)
      else $error("round robin advanced without a result");
endmodule

/* sv/wrs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_ctrl
// Sequencer for status staging, commit sweeps and the selection scans.
// ----------------------------------------------------------------------------
module wrs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  wrs_pkg::mode_type   req_mode,
   input  wrs_pkg::status_type status,
   output wrs_pkg::cmd_type    cmd,
   output logic                busy
);
   import wrs_pkg::*;

   state_type state_ff, state_in;
   how_type   how_ff, how_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         how_ff   <= HOW_COUNTER;
      end else begin
         state_ff <= state_in;
         how_ff   <= how_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      how_in   = how_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.idx_clear = 1'b1;
            if (start) begin
               unique case (req_mode)
                  MODE_STAGE: cmd.stage_write = 1'b1;
                  MODE_HB_OK: begin
                     cmd.streak_clear = 1'b1;
                     state_in = ST_COMMIT;
                  end
                  MODE_HB_PART: begin
                     if (status.streak_full) begin
                        cmd.streak_clear = 1'b1;
                        state_in = ST_COMMIT;
                     end else cmd.streak_inc = 1'b1;
                  end
                  MODE_CHOOSE: begin
                     cmd.load_req = 1'b1;
                     state_in = ST_DECIDE;
                  end
                  default: ;
               endcase
            end
         end
         ST_COMMIT: begin
            cmd.commit_step = 1'b1;
            cmd.idx_step    = 1'b1;
            if (status.idx_last) state_in = ST_IDLE;
         end
         ST_DECIDE: begin
            if (status.n_zero) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_NONE;
               cmd.how  = HOW_COUNTER;
               state_in = ST_IDLE;
            end else if (status.counter_given) begin
               cmd.mod_start = 1'b1;
               how_in   = HOW_COUNTER;
               state_in = ST_MOD;
            end else state_in = ST_SCAN_MAX;
         end
         ST_SCAN_MAX: begin
            cmd.max_step = 1'b1;
            cmd.idx_step = 1'b1;
            if (status.idx_last) state_in = ST_RATIO;
         end
         ST_RATIO: begin
            if (status.rr_needed) begin
               cmd.mod_start   = 1'b1;
               cmd.mod_from_rr = 1'b1;
               how_in   = HOW_RR;
               state_in = ST_MOD;
            end else state_in = ST_SCAN_SUM;
         end
         ST_SCAN_SUM: begin
            cmd.sum_step = 1'b1;
            cmd.idx_step = 1'b1;
            if (status.idx_last) state_in = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_SCAN_PICK;
         end
         ST_SCAN_PICK: begin
            if (status.pick_hit) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_SCAN;
               cmd.how  = HOW_WEIGHTED;
               state_in = ST_IDLE;
            end else if (status.idx_last) begin
               cmd.mod_start   = 1'b1;
               cmd.mod_from_rr = 1'b1;
               how_in   = HOW_FALLBACK;
               state_in = ST_MOD;
            end else cmd.idx_step = 1'b1;
         end
         ST_MOD: begin
            if (status.mod_done) begin
               cmd.emit       = 1'b1;
               cmd.sel        = SEL_MOD;
               cmd.how        = how_ff;
               cmd.rr_advance = (how_ff != HOW_COUNTER);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   a_mod_running: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MOD |-> status.mod_busy || status.mod_done)
      else $error("waiting on an idle remainder unit");
   a_emit_ends_item: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> state_ff == ST_IDLE) else $error("result beat without return to idle");
endmodule

/* sv/weighted_random_host_selector_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_random_host_selector_top
// Picks a target per request by counter modulo, round robin or weighted draw.
// ----------------------------------------------------------------------------
// latency of a result follows its path to the loaded result beat: counter pick
// runs the 32-step serial remainder unit, weighted pick the three 16-slot scans,
// round robin the first scan and the remainder unit, fallback all three scans
// and the remainder unit; heartbeat may add the 16-slot commit; one item at a time
// busy high until the result beat is loaded; results cannot be stalled
// reset clears configuration, presence flags, round robin index and streak
module weighted_random_host_selector_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  wrs_pkg::req_type    req_data,
   output logic                rsp_valid,
   output wrs_pkg::rsp_type    rsp_data,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [wrs_pkg::CSR_W-1:0] csr_wdata
);
   import wrs_pkg::*;

   cmd_type    cmd;
   status_type status;

   wrs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_data.mode),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   wrs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );
endmodule

/* dv/tb_weighted_random_host_selector_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_random_host_selector_top
// Self-checking bench for the weighted random host selector: beats are sent
// through the start/busy handshake with random gaps, a scoreboard predicts
// each selection beat and checks the strobed results in order, and the
// configuration is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_weighted_random_host_selector_top;
   import wrs_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 80;

   // selection predictor and store of pending selections
   class selection_scoreboard;
      logic [4:0]  host_count;
      logic [6:0]  avail_ratio;
      logic        weight_src;
      logic        stg_present [MAX_TARGETS];
      logic [31:0] stg_cache   [MAX_TARGETS];
      logic [15:0] stg_inflight[MAX_TARGETS];
      logic        act_present [MAX_TARGETS];
      logic [31:0] act_cache   [MAX_TARGETS];
      logic [15:0] act_inflight[MAX_TARGETS];
      logic [31:0] rr_index;
      logic [6:0]  streak;
      rsp_type     pending_picks[$];
      int          mismatches;

      function new();
         host_count = '0;
         avail_ratio = '0;
         weight_src = 1'b0;
         rr_index = '0;
         streak = '0;
         mismatches = 0;
         for (int i = 0; i < MAX_TARGETS; i++) begin
            stg_present[i] = 1'b0;
            stg_cache[i] = '0;
            stg_inflight[i] = '0;
            act_present[i] = 1'b0;
            act_cache[i] = '0;
            act_inflight[i] = '0;
         end
      endfunction

      function void write_reg(logic [1:0] idx, logic [6:0] value);
         case (idx)
            CSR_HOST_COUNT: host_count = value[4:0];
            CSR_AVAIL_RATIO: avail_ratio = value;
            CSR_WEIGHT_SRC: weight_src = value[0];
            default: ;
         endcase
      endfunction

      function void commit();
         for (int i = 0; i < MAX_TARGETS; i++) begin
            act_present[i] = stg_present[i];
            act_cache[i] = stg_cache[i];
            act_inflight[i] = stg_inflight[i];
         end
      endfunction

      function logic [63:0] weight(int i, logic [15:0] max_inf);
         return weight_src ? 64'(max_inf - act_inflight[i]) : 64'(act_cache[i]);
      endfunction

      // note an accepted request beat
      function void note_request(req_type rq);
         rsp_type     exp_pick;
         int          n;
         int          reported;
         logic [15:0] max_inf;
         logic [63:0] total;
         logic [63:0] running;
         logic [63:0] thr;
         bit          hit;
         case (rq.mode)
            MODE_STAGE: begin
               stg_present[rq.target_index] = rq.status_present;
               stg_cache[rq.target_index] = rq.free_cache;
               stg_inflight[rq.target_index] = rq.inflight_requests;
            end
            MODE_HB_OK: begin
               streak = '0;
               commit();
            end
            MODE_HB_PART: begin
               if (streak == STREAK_LIMIT) begin
                  streak = '0;
                  commit();
               end else begin
                  streak = streak + 7'd1;
               end
            end
            default: begin
               exp_pick = '0;
               n = (host_count > MAX_TARGETS) ? MAX_TARGETS : int'(host_count);
               if (n != 0) begin
                  exp_pick.target_found = 1'b1;
                  if (rq.counter_given) begin
                     exp_pick.chosen_target = 4'(rq.global_count % n);
                     exp_pick.how_chosen = HOW_COUNTER;
                  end else begin
                     reported = 0;
                     max_inf = '0;
                     for (int i = 0; i < MAX_TARGETS; i++) begin
                        if (act_present[i]) begin
                           reported++;
                           if (act_inflight[i] > max_inf) max_inf = act_inflight[i];
                        end
                     end
                     if (reported < (n * int'(avail_ratio)) / 100) begin
                        exp_pick.chosen_target = 4'(rr_index % n);
                        exp_pick.how_chosen = HOW_RR;
                        rr_index = rr_index + 32'd1;
                     end else begin
                        total = '0;
                        running = '0;
                        hit = 1'b0;
                        for (int i = 0; i < n; i++)
                           if (act_present[i]) total += weight(i, max_inf);
                        thr = total * 64'(rq.random_fraction);
                        for (int i = 0; i < n && !hit; i++) begin
                           if (act_present[i]) begin
                              running += weight(i, max_inf);
                              if ((running << 16) >= thr) begin
                                 exp_pick.chosen_target = 4'(i);
                                 hit = 1'b1;
                              end
                           end
                        end
                        if (hit) begin
                           exp_pick.how_chosen = HOW_WEIGHTED;
                        end else begin
                           exp_pick.chosen_target = 4'(rr_index % n);
                           exp_pick.how_chosen = HOW_FALLBACK;
                           rr_index = rr_index + 32'd1;
                        end
                     end
                  end
               end
               pending_picks.push_back(exp_pick);
            end
         endcase
      endfunction

      // compare a result beat with the oldest pending selection
      function void check_pick(rsp_type got);
         rsp_type want;
         if (pending_picks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: target %0d found %0d how %0d",
                        got.chosen_target, got.target_found, got.how_chosen);
            return;
         end
         want = pending_picks.pop_front();
         if (got.chosen_target !== want.chosen_target ||
             got.target_found !== want.target_found ||
             got.how_chosen !== want.how_chosen) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result mismatch: target %0d/%0d found %0d/%0d how %0d/%0d (exp/act)",
                        want.chosen_target, got.chosen_target, want.target_found,
                        got.target_found, want.how_chosen, got.how_chosen);
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   req_type             req_data = '0;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                csr_we = 1'b0;
   logic [1:0]          csr_index = '0;
   logic [CSR_W-1:0]    csr_wdata = '0;

   selection_scoreboard sb = new();
   int                  idle_cycles = 0;
   bit                  no_gaps = 1'b0;

   weighted_random_host_selector_top i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // monitor: accepted beats, result beats and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_request(req_data);
         if (rsp_valid) sb.check_pick(rsp_data);
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic send_beat(req_type rq);
      int gap;
      start <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
      if (no_gaps || $urandom_range(0, 2) != 0) gap = 0;
      else if ($urandom_range(0, 9) < 8) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 80);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_quiet();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_picks.size() != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [6:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      sb.write_reg(idx, value);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(logic [6:0] hosts, logic [6:0] ratio, logic [6:0] rank);
      wait_quiet();
      write_csr(CSR_HOST_COUNT, hosts);
      write_csr(CSR_AVAIL_RATIO, ratio);
      write_csr(CSR_WEIGHT_SRC, rank);
   endtask

   function automatic req_type stage_beat(int slot, bit present, logic [31:0] cache,
                                          logic [15:0] inflight);
      req_type rq;
      rq = '0;
      rq.mode = MODE_STAGE;
      rq.target_index = 4'(slot);
      rq.status_present = present;
      rq.free_cache = cache;
      rq.inflight_requests = inflight;
      return rq;
   endfunction

   function automatic req_type choose_beat(bit counter, logic [30:0] count,
                                           logic [15:0] frac);
      req_type rq;
      rq = '0;
      rq.mode = MODE_CHOOSE;
      rq.counter_given = counter;
      rq.global_count = count;
      rq.random_fraction = frac;
      return rq;
   endfunction

   function automatic req_type heartbeat(mode_type m);
      req_type rq;
      rq = '0;
      rq.mode = m;
      return rq;
   endfunction

   // random beat with full-range content
   function automatic req_type random_beat();
      req_type      rq;
      int           pick;
      logic [127:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom};
      rq = req_type'(raw[$bits(req_type)-1:0]);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         rq.mode = MODE_STAGE;
         rq.status_present = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 2) == 0) rq.free_cache = $urandom_range(0, 1000);
         if ($urandom_range(0, 2) == 0)
            rq.inflight_requests = 16'($urandom_range(0, 20));
      end else if (pick < 42) begin
         rq.mode = MODE_HB_OK;
      end else if (pick < 47) begin
         rq.mode = MODE_HB_PART;
      end else begin
         rq.mode = MODE_CHOOSE;
         rq.counter_given = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 5))
            0: rq.random_fraction = '0;
            1: rq.random_fraction = '1;
            default: ;
         endcase
      end
      return rq;
   endfunction

   task automatic random_phase(int items);
      int sent;
      sent = 0;
      no_gaps = ($urandom_range(0, 3) == 0);
      while (sent < items) begin
         if ($urandom_range(0, 59) == 0) begin
            // long partial heartbeat streak around the limit, which may reach the commit
            for (int k = $urandom_range(98, 104); k > 0; k--) begin
               send_beat(heartbeat(MODE_HB_PART));
               sent++;
            end
            send_beat(choose_beat(1'b0, '0, 16'($urandom)));
            sent++;
         end else begin
            send_beat(random_beat());
            sent++;
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty group, counter extremes, no status fallback
      configure(7'd0, 7'd0, 7'd0);
      send_beat(choose_beat(1'b0, '0, '0));
      configure(7'd4, 7'd0, 7'd0);
      send_beat(choose_beat(1'b1, 31'h7fff_ffff, '0));
      send_beat(choose_beat(1'b1, '0, '0));
      send_beat(choose_beat(1'b0, '0, 16'hffff));
      // stage extremes, slot above the group still counts for the ratio
      send_beat(stage_beat(0, 1'b1, 32'hffff_ffff, 16'h0000));
      send_beat(stage_beat(2, 1'b1, 32'h0000_0000, 16'hffff));
      send_beat(stage_beat(15, 1'b1, 32'd5, 16'd7));
      send_beat(choose_beat(1'b0, '0, '0));
      send_beat(heartbeat(MODE_HB_OK));
      send_beat(choose_beat(1'b0, '0, '0));
      send_beat(choose_beat(1'b0, '0, 16'hffff));
      send_beat(choose_beat(1'b0, '0, 16'h8000));
      send_beat(heartbeat(MODE_HB_PART));
      // inverted in-flight weight and a strict ratio giving round robin
      configure(7'd31, 7'd127, 7'd1);
      send_beat(choose_beat(1'b0, '0, 16'hffff));
      send_beat(choose_beat(1'b0, '0, 16'h0001));
      send_beat(choose_beat(1'b1, 31'd12345, '0));
      configure(7'd16, 7'd100, 7'd1);
      send_beat(choose_beat(1'b0, '0, '0));
      // zero weight sum
      configure(7'd3, 7'd1, 7'd1);
      send_beat(stage_beat(0, 1'b0, '0, '0));
      send_beat(stage_beat(2, 1'b1, '0, 16'hffff));
      send_beat(heartbeat(MODE_HB_OK));
      send_beat(choose_beat(1'b0, '0, 16'hffff));
      send_beat(choose_beat(1'b0, '0, '0));

      // random phases across settings
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: configure(7'd16, 7'd0, 7'd0);
            1: configure(7'd1, 7'd100, 7'd1);
            2: configure(7'd17, 7'd50, 7'd0);
            3: configure(7'd0, 7'd30, 7'd1);
            4: configure(7'h7f, 7'd127, 7'h7f);
            default: configure(7'($urandom_range(1, 16)), 7'($urandom_range(0, 127)),
                               7'($urandom_range(0, 1)));
         endcase
         random_phase(180);
      end

      wait_quiet();
      if (sb.mismatches == 0 && sb.pending_picks.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/wrs_pkg.sv
sv/wrs_mod.sv
sv/wrs_datapath.sv
sv/wrs_ctrl.sv
sv/weighted_random_host_selector_top.sv
dv/tb_weighted_random_host_selector_top.sv
